>>> design/ros_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_pkg
// Shared types and fixed field widths of the rectangle overlap sweep core.
// ----------------------------------------------------------------------------
package ros_pkg;

   // fixed port field widths
   localparam int NODE_W  = 10;
   localparam int COUNT_W = 11;
   localparam int COORD_W = 32;
   localparam int SIZE_W  = 31;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_SORT_KEY = 12'b0000_0000_0010,
      ST_KEY_WAIT = 12'b0000_0000_0100,
      ST_SORT_J   = 12'b0000_0000_1000,
      ST_ORD_WAIT = 12'b0000_0001_0000,
      ST_X_WAIT   = 12'b0000_0010_0000,
      ST_CHECK    = 12'b0000_0100_0000,
      ST_A_ORD    = 12'b0000_1000_0000,
      ST_A_RECT   = 12'b0001_0000_0000,
      ST_B_ORD    = 12'b0010_0000_0000,
      ST_B_RECT   = 12'b0100_0000_0000,
      ST_COMPARE  = 12'b1000_0000_0000
   } state_type;

endpackage

>>> design/ros_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ros_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> design/rectangle_overlap_sweep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_overlap_sweep_core
// Stores rectangles in RAM, sorts them by center x with an insertion sort
// on an order RAM, and sweeps for overlapping pairs one fetch at a time.
// ----------------------------------------------------------------------------
// A write item's result strobes the next cycle.
// A fetch after a change first sorts: each entry reads its x key, then steps
// back, each step a dependent order-RAM then rect-RAM read. The sweep reads
// each new outer entry and each inner entry tested against it the same way.
// One item at a time; busy drops as the result strobes; no receiver stall.
// Reset (synchronous) clears the count and control; RAMs keep their data.
module rectangle_overlap_sweep_core #(
   parameter int MAX_NODES  = 1024,
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [ros_pkg::NODE_W-1:0]    req_node_index,
   input  logic signed [ros_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [ros_pkg::COORD_W-1:0] req_center_y,
   input  logic [ros_pkg::SIZE_W-1:0]    req_box_width,
   input  logic [ros_pkg::SIZE_W-1:0]    req_box_height,
   output logic                          rsp_strobe,
   output logic                          rsp_pair_found,
   output logic                          rsp_scan_done,
   output logic [ros_pkg::NODE_W-1:0]    rsp_first_node,
   output logic [ros_pkg::NODE_W-1:0]    rsp_second_node,
   input  logic                          csr_wr_en,
   input  logic [ros_pkg::COUNT_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int NB = $clog2(MAX_NODES + 2);
   localparam int CB = COORD_BITS;
   localparam int SW = ros_pkg::SIZE_W;
   localparam int NW = ros_pkg::NODE_W;
   localparam int RW = 2 * CB + 2 * SW;
   localparam int EW = ((CB > SW) ? CB : SW) + 2;

   // control registers
   ros_pkg::state_type state_ff, state_in;
   logic need_sort_ff, need_sort_in;
   logic finished_ff, finished_in;
   logic a_loaded_ff, a_loaded_in;
   logic [NB-1:0] count_ff, count_in;
   logic [NB-1:0] outer_ff, outer_in;
   logic [NB-1:0] inner_ff, inner_in;
   logic [NB-1:0] sort_i_ff, sort_i_in;
   logic [NB-1:0] sort_j_ff, sort_j_in;

   // datapath registers
   logic signed [CB-1:0] key_x_ff, key_x_in;
   logic [AW-1:0] hold_ff, hold_in;
   logic [AW-1:0] ia_ff, ia_in;
   logic [AW-1:0] ib_ff, ib_in;
   logic signed [EW-1:0] axl_ff, axh_ff, ayl_ff, ayh_ff;
   logic signed [EW-1:0] bxl_ff, bxh_ff, byl_ff, byh_ff;
   logic a_zero_ff, b_zero_ff;
   logic load_a, load_b;

   // result registers
   logic rsp_strobe_ff, rsp_strobe_in;
   logic pair_ff, pair_in;
   logic done_ff, done_in;
   logic [NW-1:0] first_ff, first_in;
   logic [NW-1:0] second_ff, second_in;

   // memory ports
   logic          rect_wr_en;
   logic [AW-1:0] rect_wr_addr;
   logic [RW-1:0] rect_wr_data;
   logic [AW-1:0] rect_rd_addr;
   logic [RW-1:0] rect_rd_data;
   logic          order_wr_en;
   logic [AW-1:0] order_wr_addr;
   logic [AW-1:0] order_wr_data;
   logic [AW-1:0] order_rd_addr;
   logic [AW-1:0] order_rd_data;

   // decoded rect read and its doubled edges
   logic signed [CB-1:0] rd_cx, rd_cy;
   logic [SW-1:0] rd_w, rd_h;
   logic signed [EW-1:0] cx2, cy2, wx, hx;
   logic signed [EW-1:0] exl, exh, eyl, eyh;
   logic rd_zero;
   logic overlap, past_right;
   logic idx_ok;
   logic [31:0] csr_wide;

   ros_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_rect_ram (
      .clock   (clock),
      .wr_en   (rect_wr_en),
      .wr_addr (rect_wr_addr),
      .wr_data (rect_wr_data),
      .rd_addr (rect_rd_addr),
      .rd_data (rect_rd_data)
   );

   ros_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_order_ram (
      .clock   (clock),
      .wr_en   (order_wr_en),
      .wr_addr (order_wr_addr),
      .wr_data (order_wr_data),
      .rd_addr (order_rd_addr),
      .rd_data (order_rd_data)
   );

   // write item packing
   assign idx_ok       = 32'(req_node_index) < 32'(MAX_NODES);
   assign rect_wr_addr = AW'(req_node_index);
   assign rect_wr_data = {CB'(req_center_x), CB'(req_center_y), req_box_width, req_box_height};

   // rect read decode and doubled edges 2c -/+ s
   always_comb begin
      rd_cx   = $signed(rect_rd_data[RW-1 -: CB]);
      rd_cy   = $signed(rect_rd_data[2*SW +: CB]);
      rd_w    = rect_rd_data[SW +: SW];
      rd_h    = rect_rd_data[0 +: SW];
      cx2     = EW'(rd_cx) <<< 1;
      cy2     = EW'(rd_cy) <<< 1;
      wx      = $signed(EW'(rd_w));
      hx      = $signed(EW'(rd_h));
      exl     = cx2 - wx;
      exh     = cx2 + wx;
      eyl     = cy2 - hx;
      eyh     = cy2 + hx;
      rd_zero = (rd_w == '0) || (rd_h == '0);
   end

   // pair test and sweep break
   assign overlap = !a_zero_ff && !b_zero_ff &&
                    (axh_ff > bxl_ff) && (bxh_ff > axl_ff) &&
                    (ayh_ff > byl_ff) && (byh_ff > ayl_ff);
   assign past_right = bxl_ff > axh_ff;

   // saturated node count
   assign csr_wide = 32'(csr_wr_data);
   assign count_in = csr_wr_en ?
                     ((csr_wide > 32'(MAX_NODES)) ? NB'(MAX_NODES) : NB'(csr_wide)) :
                     count_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      need_sort_in  = need_sort_ff | csr_wr_en;
      finished_in   = finished_ff;
      a_loaded_in   = a_loaded_ff;
      outer_in      = outer_ff;
      inner_in      = inner_ff;
      sort_i_in     = sort_i_ff;
      sort_j_in     = sort_j_ff;
      key_x_in      = key_x_ff;
      hold_in       = hold_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      load_a        = 1'b0;
      load_b        = 1'b0;
      rect_wr_en    = 1'b0;
      rect_rd_addr  = '0;
      order_wr_en   = 1'b0;
      order_wr_addr = sort_j_ff[AW-1:0];
      order_wr_data = sort_i_ff[AW-1:0];
      order_rd_addr = '0;
      rsp_strobe_in = 1'b0;
      pair_in       = pair_ff;
      done_in       = done_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      case (state_ff)
         ros_pkg::ST_IDLE: begin
            if (start) begin
               if (req_kind == ros_pkg::KIND_WRITE) begin
                  rect_wr_en    = idx_ok;
                  need_sort_in  = 1'b1;
                  rsp_strobe_in = 1'b1;
                  pair_in       = 1'b0;
                  done_in       = 1'b0;
                  first_in      = '0;
                  second_in     = '0;
               end else if (need_sort_ff) begin
                  sort_i_in = '0;
                  state_in  = ros_pkg::ST_SORT_KEY;
               end else begin
                  state_in = ros_pkg::ST_CHECK;
               end
            end
         end
         ros_pkg::ST_SORT_KEY: begin
            if (sort_i_ff >= count_ff) begin
               need_sort_in = 1'b0;
               outer_in     = '0;
               inner_in     = NB'(1);
               finished_in  = 1'b0;
               a_loaded_in  = 1'b0;
               state_in     = ros_pkg::ST_CHECK;
            end else begin
               rect_rd_addr = sort_i_ff[AW-1:0];
               sort_j_in    = sort_i_ff;
               state_in     = ros_pkg::ST_KEY_WAIT;
            end
         end
         ros_pkg::ST_KEY_WAIT: begin
            key_x_in = rd_cx;
            state_in = ros_pkg::ST_SORT_J;
         end
         ros_pkg::ST_SORT_J: begin
            if (sort_j_ff == '0) begin
               order_wr_en = 1'b1;
               sort_i_in   = sort_i_ff + NB'(1);
               state_in    = ros_pkg::ST_SORT_KEY;
            end else begin
               order_rd_addr = AW'(sort_j_ff - NB'(1));
               state_in      = ros_pkg::ST_ORD_WAIT;
            end
         end
         ros_pkg::ST_ORD_WAIT: begin
            hold_in      = order_rd_data;
            rect_rd_addr = order_rd_data;
            state_in     = ros_pkg::ST_X_WAIT;
         end
         ros_pkg::ST_X_WAIT: begin
            // shift the larger entry up, or drop the key in place
            order_wr_en = 1'b1;
            if (rd_cx > key_x_ff) begin
               order_wr_data = hold_ff;
               sort_j_in     = sort_j_ff - NB'(1);
               state_in      = ros_pkg::ST_SORT_J;
            end else begin
               sort_i_in = sort_i_ff + NB'(1);
               state_in  = ros_pkg::ST_SORT_KEY;
            end
         end
         ros_pkg::ST_CHECK: begin
            if (finished_ff || (outer_ff >= count_ff)) begin
               finished_in   = 1'b1;
               rsp_strobe_in = 1'b1;
               pair_in       = 1'b0;
               done_in       = 1'b1;
               first_in      = '0;
               second_in     = '0;
               state_in      = ros_pkg::ST_IDLE;
            end else if (inner_ff >= count_ff) begin
               outer_in    = outer_ff + NB'(1);
               inner_in    = outer_ff + NB'(2);
               a_loaded_in = 1'b0;
            end else if (!a_loaded_ff) begin
               order_rd_addr = outer_ff[AW-1:0];
               state_in      = ros_pkg::ST_A_ORD;
            end else begin
               order_rd_addr = inner_ff[AW-1:0];
               state_in      = ros_pkg::ST_B_ORD;
            end
         end
         ros_pkg::ST_A_ORD: begin
            ia_in        = order_rd_data;
            rect_rd_addr = order_rd_data;
            state_in     = ros_pkg::ST_A_RECT;
         end
         ros_pkg::ST_A_RECT: begin
            load_a      = 1'b1;
            a_loaded_in = 1'b1;
            state_in    = ros_pkg::ST_CHECK;
         end
         ros_pkg::ST_B_ORD: begin
            ib_in        = order_rd_data;
            rect_rd_addr = order_rd_data;
            state_in     = ros_pkg::ST_B_RECT;
         end
         ros_pkg::ST_B_RECT: begin
            load_b   = 1'b1;
            state_in = ros_pkg::ST_COMPARE;
         end
         ros_pkg::ST_COMPARE: begin
            if (overlap) begin
               inner_in      = inner_ff + NB'(1);
               rsp_strobe_in = 1'b1;
               pair_in       = 1'b1;
               done_in       = 1'b0;
               first_in      = NW'(ia_ff);
               second_in     = NW'(ib_ff);
               state_in      = ros_pkg::ST_IDLE;
            end else if (past_right) begin
               outer_in    = outer_ff + NB'(1);
               inner_in    = outer_ff + NB'(2);
               a_loaded_in = 1'b0;
               state_in    = ros_pkg::ST_CHECK;
            end else begin
               inner_in = inner_ff + NB'(1);
               state_in = ros_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = ros_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ros_pkg::ST_IDLE;
         need_sort_ff  <= 1'b1;
         finished_ff   <= 1'b0;
         a_loaded_ff   <= 1'b0;
         count_ff      <= '0;
         outer_ff      <= '0;
         inner_ff      <= '0;
         sort_i_ff     <= '0;
         sort_j_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         need_sort_ff  <= need_sort_in;
         finished_ff   <= finished_in;
         a_loaded_ff   <= a_loaded_in;
         count_ff      <= count_in;
         outer_ff      <= outer_in;
         inner_ff      <= inner_in;
         sort_i_ff     <= sort_i_in;
         sort_j_ff     <= sort_j_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_x_ff  <= key_x_in;
      hold_ff   <= hold_in;
      ia_ff     <= ia_in;
      ib_ff     <= ib_in;
      pair_ff   <= pair_in;
      done_ff   <= done_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      if (load_a) begin
         axl_ff    <= exl;
         axh_ff    <= exh;
         ayl_ff    <= eyl;
         ayh_ff    <= eyh;
         a_zero_ff <= rd_zero;
      end
      if (load_b) begin
         bxl_ff    <= exl;
         bxh_ff    <= exh;
         byl_ff    <= eyl;
         byh_ff    <= eyh;
         b_zero_ff <= rd_zero;
      end
   end

   assign busy            = (state_ff != ros_pkg::ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pair_found  = pair_ff;
   assign rsp_scan_done   = done_ff;
   assign rsp_first_node  = first_ff;
   assign rsp_second_node = second_ff;

   // checks
   a_pair_xor_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_pair_found && rsp_scan_done))
      else $error("pair and done reported together");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while sequencer busy");

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == ros_pkg::KIND_WRITE)) |=>
         (rsp_strobe && !rsp_pair_found && !rsp_scan_done))
      else $error("write item result missing or wrong");

   a_inner_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ros_pkg::ST_COMPARE) |-> (inner_ff > outer_ff))
      else $error("inner cursor not ahead of outer");

endmodule

>>> bench/tb_rectangle_overlap_sweep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_overlap_sweep_core
// Self-checking bench for the rectangle overlap sweep core. A directed table
// covers field extremes, zero sizes, touching edges and the done state. Random
// phases then fill small rectangle sets, set the count, sweep up to 40 fetches.
// A last phase fills all 1024 entries and runs the count at its saturating
// extremes. Every result is checked against an in-bench sweep predictor.
// ----------------------------------------------------------------------------
module tb_rectangle_overlap_sweep_core;

   localparam int   NODE_W     = ros_pkg::NODE_W;
   localparam int   COUNT_W    = ros_pkg::COUNT_W;
   localparam int   COORD_W    = ros_pkg::COORD_W;
   localparam int   SIZE_W     = ros_pkg::SIZE_W;
   localparam logic KIND_WRITE = ros_pkg::KIND_WRITE;
   localparam logic KIND_FETCH = ros_pkg::KIND_FETCH;

   localparam int NODES = 1024;

   typedef struct {
      logic                     kind;
      logic [NODE_W-1:0]        node;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [SIZE_W-1:0]        w;
      logic [SIZE_W-1:0]        h;
   } rect_item_type;

   typedef struct packed {
      logic              found;
      logic              done;
      logic [NODE_W-1:0] first;
      logic [NODE_W-1:0] second;
   } pair_answer_type;

   typedef struct {
      int              count_before;  // -1: no register write before this row
      rect_item_type   item;
      bit              typed;
      pair_answer_type answer;
   } table_row_type;

   logic clock, reset, start, busy;
   logic req_kind;
   logic [NODE_W-1:0] req_node_index;
   logic signed [COORD_W-1:0] req_center_x, req_center_y;
   logic [SIZE_W-1:0] req_box_width, req_box_height;
   logic rsp_strobe, rsp_pair_found, rsp_scan_done;
   logic [NODE_W-1:0] rsp_first_node, rsp_second_node;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   rectangle_overlap_sweep_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_node_index(req_node_index),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_box_width(req_box_width), .req_box_height(req_box_height),
      .rsp_strobe(rsp_strobe), .rsp_pair_found(rsp_pair_found),
      .rsp_scan_done(rsp_scan_done), .rsp_first_node(rsp_first_node),
      .rsp_second_node(rsp_second_node),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // clock, 10 ns period
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // predictor state
   logic signed [COORD_W-1:0] rect_cx [NODES];
   logic signed [COORD_W-1:0] rect_cy [NODES];
   logic [SIZE_W-1:0]         rect_w  [NODES];
   logic [SIZE_W-1:0]         rect_h  [NODES];
   bit                        written [NODES];
   int                        x_order [NODES];
   bit  resort_due = 1'b1;
   int  sweep_i, sweep_j;
   bit  sweep_over;
   int  count_reg = 0;

   pair_answer_type expected_answers[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  pairs_seen = 0;
   int  burst_left = 0;

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // doubled edges: 2c - s and 2c + s
   function automatic longint left_edge(logic signed [COORD_W-1:0] c, logic [SIZE_W-1:0] s);
      return 2 * longint'(c) - longint'(s);
   endfunction

   function automatic longint right_edge(logic signed [COORD_W-1:0] c, logic [SIZE_W-1:0] s);
      return 2 * longint'(c) + longint'(s);
   endfunction

   function automatic bit span_overlap(logic signed [COORD_W-1:0] c1, logic [SIZE_W-1:0] s1,
                                       logic signed [COORD_W-1:0] c2, logic [SIZE_W-1:0] s2);
      if (s1 == 0 || s2 == 0) return 1'b0;
      return right_edge(c1, s1) > left_edge(c2, s2) && right_edge(c2, s2) > left_edge(c1, s1);
   endfunction

   // next answer of the sweep for one accepted item
   function automatic pair_answer_type next_pair(rect_item_type it);
      pair_answer_type ans;
      int n, a, b, k, j;
      ans = '{1'b0, 1'b0, '0, '0};
      n = (count_reg > NODES) ? NODES : count_reg;
      if (it.kind == KIND_WRITE) begin
         rect_cx[it.node] = it.cx;
         rect_cy[it.node] = it.cy;
         rect_w[it.node]  = it.w;
         rect_h[it.node]  = it.h;
         written[it.node] = 1'b1;
         resort_due = 1'b1;
         return ans;
      end
      // stable insertion sort on center x
      if (resort_due) begin
         for (k = 0; k < n; k++) begin
            j = k;
            while (j > 0 && rect_cx[x_order[j-1]] > rect_cx[k]) begin
               x_order[j] = x_order[j-1];
               j--;
            end
            x_order[j] = k;
         end
         resort_due = 1'b0;
         sweep_i = 0;
         sweep_j = 1;
         sweep_over = 1'b0;
      end
      while (!sweep_over) begin
         if (sweep_i >= n) begin
            sweep_over = 1'b1;
            break;
         end
         if (sweep_j >= n) begin
            sweep_i++;
            sweep_j = sweep_i + 1;
            continue;
         end
         a = x_order[sweep_i];
         b = x_order[sweep_j];
         if (span_overlap(rect_cx[a], rect_w[a], rect_cx[b], rect_w[b]) &&
             span_overlap(rect_cy[a], rect_h[a], rect_cy[b], rect_h[b])) begin
            sweep_j++;
            ans.found  = 1'b1;
            ans.first  = a[NODE_W-1:0];
            ans.second = b[NODE_W-1:0];
            return ans;
         end
         if (left_edge(rect_cx[b], rect_w[b]) > right_edge(rect_cx[a], rect_w[a])) begin
            sweep_i++;
            sweep_j = sweep_i + 1;
         end else begin
            sweep_j++;
         end
      end
      ans.done = 1'b1;
      return ans;
   endfunction

   // result monitor
   always @(posedge clock) begin
      pair_answer_type e;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            flag_mismatch("result with no item outstanding");
         end else begin
            e = expected_answers.pop_front();
            if (rsp_pair_found !== e.found)
               flag_mismatch($sformatf("pair_found %b, want %b", rsp_pair_found, e.found));
            if (rsp_scan_done !== e.done)
               flag_mismatch($sformatf("scan_done %b, want %b", rsp_scan_done, e.done));
            if (rsp_first_node !== e.first)
               flag_mismatch($sformatf("first_node %0d, want %0d", rsp_first_node, e.first));
            if (rsp_second_node !== e.second)
               flag_mismatch($sformatf("second_node %0d, want %0d", rsp_second_node, e.second));
            if (e.found) pairs_seen++;
         end
      end
   end

   // drive one item and wait for it to be taken
   task automatic send_item(input rect_item_type it, output pair_answer_type ans);
      @(negedge clock);
      start          <= 1'b1;
      req_kind       <= it.kind;
      req_node_index <= it.node;
      req_center_x   <= it.cx;
      req_center_y   <= it.cy;
      req_box_width  <= it.w;
      req_box_height <= it.h;
      do @(posedge clock); while (busy);
      ans = next_pair(it);
      expected_answers = {expected_answers, ans};
      items_sent++;
   endtask

   // bursts of back-to-back items with random gaps between them
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // register write, only with the core idle
   task automatic set_count(input int value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[COUNT_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      count_reg   = value;
      resort_due  = 1'b1;
   endtask

   function automatic rect_item_type make_rect(int node, int cx, int cy, int w, int h);
      rect_item_type it;
      it.kind = KIND_WRITE;
      it.node = node[NODE_W-1:0];
      it.cx = cx; it.cy = cy;
      it.w = w[SIZE_W-1:0]; it.h = h[SIZE_W-1:0];
      return it;
   endfunction

   function automatic rect_item_type fetch_item();
      rect_item_type it;
      logic [31:0] r_node, r_w, r_h;
      r_node = $urandom();
      r_w = $urandom();
      r_h = $urandom();
      it.kind = KIND_FETCH;
      it.node = r_node[NODE_W-1:0];
      it.cx = $urandom(); it.cy = $urandom();
      it.w = r_w[SIZE_W-1:0]; it.h = r_h[SIZE_W-1:0];
      return it;
   endfunction

   // random rectangle: mostly a crowded small window, sometimes any bits
   function automatic rect_item_type random_rect(int node);
      if ($urandom_range(0, 9) < 7)
         return make_rect(node, $signed($urandom_range(0, 16 << 16)) - (8 << 16),
                          $signed($urandom_range(0, 16 << 16)) - (8 << 16),
                          $urandom_range(0, 8 << 16), $urandom_range(0, 8 << 16));
      return make_rect(node, $urandom(), $urandom(), $urandom(), $urandom());
   endfunction

   // largest n with entries 0..n-1 all written
   function automatic int filled_prefix();
      int n;
      n = 0;
      while (n < NODES && written[n]) n++;
      return n;
   endfunction

   table_row_type directed[$];

   function automatic void add_row(int cnt, rect_item_type it, bit typed,
                                   bit found, bit done);
      table_row_type r;
      r.count_before = cnt;
      r.item = it;
      r.typed = typed;
      r.answer = '{found, done, '0, '0};
      directed = {directed, r};
   endfunction

   task automatic sweep_to_end(input int cap, input bit noisy);
      pair_answer_type ans;
      int k;
      for (k = 0; k < cap; k++) begin
         if (noisy) pace();
         send_item(fetch_item(), ans);
         if (ans.done) break;
      end
   endtask

   initial begin
      pair_answer_type ans;
      rect_item_type it;
      int n, k, nodes_limit, phases, cnt;
      start = 1'b0; reset = 1'b1; csr_wr_en = 1'b0; csr_wr_data = '0;
      req_kind = KIND_WRITE; req_node_index = '0;
      req_center_x = '0; req_center_y = '0; req_box_width = '0; req_box_height = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: count zero, field extremes, zero size, touching edges
      add_row(-1, fetch_item(), 1'b1, 1'b0, 1'b1);
      add_row(-1, make_rect(0, 32'h8000_0000, 32'h7fff_ffff, -1, -1), 1'b1, 1'b0, 1'b0);
      add_row(-1, make_rect(1, 32'h7fff_ffff, 32'h8000_0000, -1, -1), 1'b1, 1'b0, 1'b0);
      add_row(-1, make_rect(2, 0, 0, 2 << 16, 2 << 16), 1'b1, 1'b0, 1'b0);
      add_row(-1, make_rect(3, 1 << 16, 0, 2 << 16, 0), 1'b1, 1'b0, 1'b0);
      add_row(-1, make_rect(4, 1 << 16, 1 << 16, 2 << 16, 2 << 16), 1'b1, 1'b0, 1'b0);
      add_row(-1, make_rect(5, 3 << 16, 1 << 16, 2 << 16, 2 << 16), 1'b1, 1'b0, 1'b0);
      add_row(-1, make_rect(1023, 32'hffff_ffff, 1, 1, 32'h7fff_ffff), 1'b1, 1'b0, 1'b0);
      add_row(6, fetch_item(), 1'b0, 1'b0, 1'b0);
      for (k = 0; k < 6; k++) add_row(-1, fetch_item(), 1'b0, 1'b0, 1'b0);
      add_row(-1, make_rect(3, 1 << 16, 0, 2 << 16, 1 << 16), 1'b1, 1'b0, 1'b0);
      for (k = 0; k < 6; k++) add_row(-1, fetch_item(), 1'b0, 1'b0, 1'b0);
      add_row(0, fetch_item(), 1'b1, 1'b0, 1'b1);

      foreach (directed[r]) begin
         if (directed[r].count_before >= 0) set_count(directed[r].count_before);
         send_item(directed[r].item, ans);
         if (directed[r].typed && ans != directed[r].answer)
            flag_mismatch($sformatf("predictor disagrees with table row %0d", r));
      end

      // random phases on small sets
      phases = 0;
      while (items_sent < 120) begin
         n = $urandom_range(2, 24);
         for (k = 0; k < n; k++) begin
            pace();
            send_item(random_rect(k), ans);
         end
         // stray writes, some outside the active set
         repeat ($urandom_range(0, 2)) begin
            pace();
            send_item(random_rect($urandom_range(0, NODES - 1)), ans);
         end
         nodes_limit = filled_prefix();
         cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n;
         if (cnt > nodes_limit) cnt = nodes_limit;
         set_count(cnt);
         sweep_to_end(40, 1'b1);
         // a write mid-sweep restarts it
         if ($urandom_range(0, 3) == 0) begin
            send_item(random_rect($urandom_range(0, n - 1)), ans);
            sweep_to_end(40, 1'b1);
         end
         send_item(fetch_item(), ans);
         if (phases % 10 == 3) drain();
         phases++;
      end

      // full set in ascending x so the sort moves nothing
      for (k = 0; k < NODES; k++) begin
         pace();
         it = make_rect(k, (k * 4 - 2048) << 16,
                        $signed($urandom_range(0, 4 << 16)) - (2 << 16),
                        $urandom_range(1 << 16, 5 << 16), $urandom_range(1 << 16, 4 << 16));
         send_item(it, ans);
      end
      set_count(NODES);
      sweep_to_end(40, 1'b1);
      set_count(2047);
      sweep_to_end(30, 1'b0);
      set_count(1500);
      sweep_to_end(20, 1'b0);
      set_count(0);
      send_item(fetch_item(), ans);

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d items over %0d small-set phases and a full 1024-entry set;",
               items_sent, phases);
      $display("%0d overlapping pairs were reported and checked.", pairs_seen);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("rectangle_overlap_sweep_core verification clean");
      end else begin
         $display("rectangle_overlap_sweep_core verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      $display("rectangle_overlap_sweep_core verification failed");
      $finish;
   end

endmodule

>>> files.f
design/ros_pkg.sv
design/ros_ram.sv
design/rectangle_overlap_sweep_core.sv
bench/tb_rectangle_overlap_sweep_core.sv
